/* sv/uart_line_assembler_queue_macros.svh */
// Assertion macros for the line assembler checker
`ifndef UART_LINE_ASSEMBLER_QUEUE_MACROS_SVH
`define UART_LINE_ASSEMBLER_QUEUE_MACROS_SVH

// check a property on every clock while out of reset
`define ULAQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition is followed by another on the next clock
`define ULAQ_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* sv/ulaq_pkg.sv */
// Shared types, codes and constants of the line assembler
`timescale 1ns / 1ps

package ulaq_pkg;

    localparam int LINE_LEN_DEF    = 64;
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int W_REQ  = 2;
    localparam int W_BYTE = 8;
    localparam int W_KIND = 2;
    localparam int W_LW   = 4;
    localparam int W_TOUT = 16;
    localparam int W_ODATA = 16;

    localparam logic [W_TOUT-1:0] IDLE_TIMEOUT_RST = 16'd30;

    localparam logic [W_BYTE-1:0] CHAR_CR = 8'h0D;
    localparam logic [W_BYTE-1:0] CHAR_LF = 8'h0A;
    localparam logic [W_BYTE-1:0] CHAR_NUL = 8'h00;

    localparam logic [W_REQ-1:0] REQ_BYTE = 2'd0;
    localparam logic [W_REQ-1:0] REQ_TICK = 2'd1;
    localparam logic [W_REQ-1:0] REQ_POP  = 2'd2;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [W_KIND-1:0] KIND_STATUS = 2'd0;
    localparam logic [W_KIND-1:0] KIND_LINE   = 2'd1;
    localparam logic [W_KIND-1:0] KIND_EMPTY  = 2'd2;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    typedef struct packed {
        logic [1:0]        op;
        logic [W_BYTE-1:0] data;
        logic              eol;
        logic              nul;
    } t_cmd;

    typedef struct packed {
        logic [W_KIND-1:0] kind;
        logic [W_BYTE-1:0] out_byte;
        logic              last;
        logic [W_LW-1:0]   lines_waiting;
        logic              has_lines;
        logic              dropping;
    } t_res;

endpackage

/* sv/ulaq_front.sv */
// Front end: accept input beats and decode them into commands
`timescale 1ns / 1ps

module ulaq_front (
    input  logic                        i_valid,
    input  logic [ulaq_pkg::W_REQ-1:0]  i_req,
    input  logic [ulaq_pkg::W_BYTE-1:0] i_byte,
    output logic                        o_ready,
    input  logic                        i_q_full,
    output logic                        o_push,
    output ulaq_pkg::t_cmd              o_cmd
);

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_cmd.data = i_byte;
        o_cmd.eol  = (i_byte == ulaq_pkg::CHAR_CR) || (i_byte == ulaq_pkg::CHAR_LF);
        o_cmd.nul  = (i_byte == ulaq_pkg::CHAR_NUL);
        unique case (i_req)
            ulaq_pkg::REQ_BYTE: o_cmd.op = ulaq_pkg::OP_BYTE;
            ulaq_pkg::REQ_TICK: o_cmd.op = ulaq_pkg::OP_TICK;
            ulaq_pkg::REQ_POP:  o_cmd.op = ulaq_pkg::OP_POP;
            default:            o_cmd.op = ulaq_pkg::OP_NOP;
        endcase
    end

endmodule

/* sv/ulaq_fifo.sv */
// Short command queue between front and back end
`timescale 1ns / 1ps

module ulaq_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ulaq_pkg::t_cmd i_data,
    output logic           o_full,
    output logic           o_valid,
    output ulaq_pkg::t_cmd o_data,
    input  logic           i_pop
);

    localparam logic [ulaq_pkg::CMDQ_PW-1:0] PTR_MAX = ulaq_pkg::CMDQ_PW'(ulaq_pkg::CMDQ_DEPTH - 1);
    localparam logic [ulaq_pkg::CMDQ_CW-1:0] CNT_MAX = ulaq_pkg::CMDQ_CW'(ulaq_pkg::CMDQ_DEPTH);

    ulaq_pkg::t_cmd                r_data [ulaq_pkg::CMDQ_DEPTH];
    logic [ulaq_pkg::CMDQ_PW-1:0]  r_wptr, r_rptr;
    logic [ulaq_pkg::CMDQ_CW-1:0]  r_count;
    logic                          push, pop;

    assign o_full  = (r_count == CNT_MAX);
    assign o_valid = (r_count != '0);
    assign o_data  = r_data[r_rptr];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PTR_MAX) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PTR_MAX) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_data[r_wptr] <= i_data;
        end
    end

endmodule

/* sv/ulaq_back.sv */
// Back end: line building, slot ring, idle timer and line streaming
`timescale 1ns / 1ps

module ulaq_back #(
    parameter int LINE_LEN    = ulaq_pkg::LINE_LEN_DEF,
    parameter int QUEUE_DEPTH = ulaq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ulaq_pkg::W_TOUT-1:0] i_idle_timeout,
    input  logic                        i_cmd_valid,
    input  ulaq_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_ready,
    output logic                        o_res_valid,
    output ulaq_pkg::t_res              o_res,
    input  logic                        i_res_ready
);

    localparam int CNT_W  = $clog2(LINE_LEN);
    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int QW     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_D  = LINE_LEN * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);

    localparam logic [CNT_W-1:0]  LAST_IDX = CNT_W'(LINE_LEN - 1);
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(QUEUE_DEPTH - 1);
    localparam logic [QW-1:0]     QFULL    = QW'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] ROW      = ADDR_W'(LINE_LEN);

    localparam logic ST_CMD = 1'b0;
    localparam logic ST_POP = 1'b1;

    logic [ulaq_pkg::W_BYTE-1:0] r_mem [MEM_D];
    logic [CNT_W-1:0]            r_len [QUEUE_DEPTH];
    logic [ulaq_pkg::W_BYTE-1:0] r_rd_data;

    logic                        r_state, n_state;
    logic [CNT_W-1:0]            r_build, n_build;
    logic [ulaq_pkg::W_TOUT-1:0] r_idle, n_idle;
    logic [SLOT_W-1:0]           r_head, n_head;
    logic [SLOT_W-1:0]           r_tail, n_tail;
    logic [QW-1:0]               r_queued, n_queued;
    logic                        r_drop, n_drop;

    logic [SLOT_W-1:0]           r_pop_slot;
    logic [CNT_W-1:0]            r_pop_idx, r_pop_len;

    logic                        r_ovalid;
    logic [ulaq_pkg::W_KIND-1:0] r_okind;
    logic                        r_olast;
    logic [QW-1:0]               r_oqueued;
    logic                        r_odrop;

    logic                        out_free, take, full, do_close;
    logic                        wr_en, len_we, rd_en;
    logic [ADDR_W-1:0]           wr_addr, rd_addr;
    logic [CNT_W-1:0]            head_len;
    logic                        pop_hit, stream_last;
    logic [CNT_W:0]              idx_next;
    logic [QW+ulaq_pkg::W_LW-1:0] queued_ext;

    assign out_free    = !r_ovalid || i_res_ready;
    assign o_cmd_ready = (r_state == ST_CMD) && out_free;
    assign take        = i_cmd_valid && o_cmd_ready;
    assign full        = (r_queued == QFULL);
    assign head_len    = r_len[r_head];
    assign pop_hit     = (r_queued != '0) && (head_len != '0);
    assign idx_next    = {1'b0, r_pop_idx} + 1'b1;
    assign stream_last = (idx_next == {1'b0, r_pop_len});
    assign wr_addr     = ADDR_W'(ADDR_W'(r_tail) * ROW) + ADDR_W'(r_build);

    always_comb begin
        n_build  = r_build;
        n_idle   = r_idle;
        n_head   = r_head;
        n_tail   = r_tail;
        n_queued = r_queued;
        n_drop   = r_drop;
        do_close = 1'b0;
        wr_en    = 1'b0;
        len_we   = 1'b0;
        if (take) begin
            unique case (i_cmd.op)
                ulaq_pkg::OP_BYTE: begin
                    n_idle = i_idle_timeout;
                    if (r_drop) begin
                        if (i_cmd.eol) begin
                            n_drop = 1'b0;
                        end
                    end else if (i_cmd.eol) begin
                        do_close = 1'b1;
                    end else if (i_cmd.nul) begin
                        n_drop = r_drop;
                    end else if (full) begin
                        n_drop  = 1'b1;
                        n_build = '0;
                    end else if (r_build < LAST_IDX) begin
                        wr_en   = 1'b1;
                        n_build = r_build + 1'b1;
                    end else begin
                        do_close = 1'b1;
                    end
                end
                ulaq_pkg::OP_TICK: begin
                    if (!full && (r_idle != '0)) begin
                        n_idle = r_idle - 1'b1;
                        if (r_idle == ulaq_pkg::W_TOUT'(1)) begin
                            do_close = 1'b1;
                        end
                    end
                end
                ulaq_pkg::OP_POP: begin
                    if (r_queued != '0) begin
                        n_head   = (r_head == SLOT_MAX) ? '0 : r_head + 1'b1;
                        n_queued = r_queued - 1'b1;
                    end
                end
                default: begin
                    n_idle = r_idle;
                end
            endcase
            if (do_close && (r_build != '0)) begin
                n_build = '0;
                if (full) begin
                    n_drop = 1'b1;
                end else begin
                    len_we   = 1'b1;
                    n_tail   = (r_tail == SLOT_MAX) ? '0 : r_tail + 1'b1;
                    n_queued = r_queued + 1'b1;
                end
            end
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(ADDR_W'(r_pop_slot) * ROW) + ADDR_W'(r_pop_idx);
        n_state = r_state;
        if (take) begin
            if ((i_cmd.op == ulaq_pkg::OP_POP) && pop_hit) begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(ADDR_W'(r_head) * ROW);
                if (head_len != CNT_W'(1)) begin
                    n_state = ST_POP;
                end
            end
        end else if ((r_state == ST_POP) && out_free) begin
            rd_en = 1'b1;
            if (stream_last) begin
                n_state = ST_CMD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CMD;
            r_build  <= '0;
            r_idle   <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_queued <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_build  <= n_build;
            r_idle   <= n_idle;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_queued <= n_queued;
            r_drop   <= n_drop;
            if (take || ((r_state == ST_POP) && out_free)) begin
                r_ovalid <= 1'b1;
            end else if (i_res_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_oqueued  <= n_queued;
            r_odrop    <= n_drop;
            r_pop_slot <= r_head;
            r_pop_idx  <= CNT_W'(1);
            r_pop_len  <= head_len;
            if (i_cmd.op == ulaq_pkg::OP_POP) begin
                r_okind <= pop_hit ? ulaq_pkg::KIND_LINE : ulaq_pkg::KIND_EMPTY;
                r_olast <= !pop_hit || (head_len == CNT_W'(1));
            end else begin
                r_okind <= ulaq_pkg::KIND_STATUS;
                r_olast <= 1'b1;
            end
        end else if ((r_state == ST_POP) && out_free) begin
            r_okind   <= ulaq_pkg::KIND_LINE;
            r_olast   <= stream_last;
            r_pop_idx <= idx_next[CNT_W-1:0];
        end
        if (len_we) begin
            r_len[r_tail] <= r_build;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign queued_ext = (QW + ulaq_pkg::W_LW)'(r_oqueued);

    assign o_res_valid         = r_ovalid;
    assign o_res.kind          = r_okind;
    assign o_res.out_byte      = (r_okind == ulaq_pkg::KIND_LINE) ? r_rd_data : '0;
    assign o_res.last          = r_olast;
    assign o_res.lines_waiting = queued_ext[ulaq_pkg::W_LW-1:0];
    assign o_res.has_lines     = (r_oqueued != '0);
    assign o_res.dropping      = r_odrop;

endmodule

/* sv/uart_line_assembler_queue.sv */
// Top level of the UART line assembler with slot queue and idle timeout
`timescale 1ns / 1ps

// Received bytes, millisecond ticks and pop requests enter on the slave stream
// and pass a two-entry command queue to the back end. A byte, a tick or an
// unused request code gives one status beat. A pop of a line of n characters
// gives n beats, one per cycle while the output is not stalled, each read
// through the single read port of the LINE_LEN x QUEUE_DEPTH byte line memory;
// a pop on an empty queue gives one beat. The back end takes no new command
// until the last beat of a pop has been loaded into the output register. The
// line memory holds no reset contents and needs no clearing pass.
module uart_line_assembler_queue #(
    parameter int LINE_LEN    = ulaq_pkg::LINE_LEN_DEF,
    parameter int QUEUE_DEPTH = ulaq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [ulaq_pkg::W_BYTE-1:0]  s_axis_tdata,   // rx_byte
    input  logic [ulaq_pkg::W_REQ-1:0]   s_axis_tuser,   // req_type
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [ulaq_pkg::W_ODATA-1:0] m_axis_tdata,   // out_byte, lines_waiting,
                                                         // has_lines, dropping, zero pad
    output logic [ulaq_pkg::W_KIND-1:0]  m_axis_tuser,   // kind
    output logic                         m_axis_tlast,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ulaq_pkg::W_TOUT-1:0]  i_cfg_data      // idle_timeout
);

    logic [ulaq_pkg::W_TOUT-1:0] r_idle_timeout;
    logic                        q_full, q_push, q_valid, q_pop;
    ulaq_pkg::t_cmd              f_cmd, q_cmd;
    ulaq_pkg::t_res              res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= ulaq_pkg::IDLE_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            r_idle_timeout <= i_cfg_data;
        end
    end

    ulaq_front u_front (
        .i_valid  (s_axis_tvalid),
        .i_req    (s_axis_tuser),
        .i_byte   (s_axis_tdata),
        .o_ready  (s_axis_tready),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (f_cmd)
    );

    ulaq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    ulaq_back #(
        .LINE_LEN    (LINE_LEN),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_idle_timeout (r_idle_timeout),
        .i_cmd_valid    (q_valid),
        .i_cmd          (q_cmd),
        .o_cmd_ready    (q_pop),
        .o_res_valid    (m_axis_tvalid),
        .o_res          (res),
        .i_res_ready    (m_axis_tready)
    );

    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;
    assign m_axis_tdata = {2'b00, res.dropping, res.has_lines,
                           res.lines_waiting, res.out_byte};

endmodule

/* sv/ulaq_checker.sv */
// Port-level assertions for the line assembler, bound to the top level
`timescale 1ns / 1ps
`include "uart_line_assembler_queue_macros.svh"

module ulaq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic line_mid_beat;
    logic res_stall;

    assign line_mid_beat = m_axis_tvalid && m_axis_tready && !m_axis_tlast
                           && (m_axis_tuser == ulaq_pkg::KIND_LINE);
    assign res_stall     = m_axis_tvalid && !m_axis_tready;

    `ULAQ_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, res_stall,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "stalled result beat changed")
    `ULAQ_ASSERT(a_single_last, i_clk, i_rst_n,
        !m_axis_tvalid || m_axis_tlast || (m_axis_tuser == ulaq_pkg::KIND_LINE),
        "status or empty beat without last")
    `ULAQ_ASSERT_NEXT(a_line_follow, i_clk, i_rst_n, line_mid_beat,
        m_axis_tvalid && (m_axis_tuser == ulaq_pkg::KIND_LINE),
        "line stream broken before last beat")
    `ULAQ_ASSERT_NEXT(a_line_status, i_clk, i_rst_n, line_mid_beat,
        m_axis_tdata[13:8] == $past(m_axis_tdata[13:8]),
        "status changed within a line")

endmodule

bind uart_line_assembler_queue ulaq_checker u_ulaq_checker (.*);
